[rtl/stbl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package stbl_pkg;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_DUP      = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        logic cmp_en;
        logic ins_en;
        logic del_en;
    } cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/stbl_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module stbl_cell #(
    parameter int INDEX     = 0,
    parameter int KEY_WIDTH = 32,
    parameter int CNT_W     = 7
) (
    input  wire                     clk,
    input  stbl_pkg::cell_ctrl_t    ctrl,
    input  wire [KEY_WIDTH-1:0]     key,
    input  wire [CNT_W-1:0]         count,
    input  wire [KEY_WIDTH-1:0]     entry_in,
    input  wire                     seen_in,
    output logic [KEY_WIDTH-1:0]    entry_out,
    output logic                    seen_out
);
    import stbl_pkg::*;

    logic [KEY_WIDTH-1:0] entry_reg;
    logic [KEY_WIDTH-1:0] entry_next;
    logic                 match_reg;
    logic                 match_next;
    logic                 live;

    assign live     = CNT_W'(INDEX) < count;
    assign seen_out = seen_in | match_reg;
    assign entry_out = entry_reg;

    always_comb
    begin
        match_next = match_reg;
        if (ctrl.cmp_en)
        begin
            match_next = live && (entry_reg == key);
        end
    end

    always_comb
    begin
        entry_next = entry_reg;
        priority if (ctrl.del_en && seen_out)
        begin
            entry_next = entry_in;
        end
        else if (ctrl.ins_en && (count == CNT_W'(INDEX)))
        begin
            entry_next = key;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        match_reg <= match_next;
    end

endmodule

`default_nettype wire

[rtl/set_table_insert_delete_lookup.sv]
`timescale 1ns / 1ps
`default_nettype none

// Set of distinct keys held in a row of CAPACITY cells, packed from cell 0 up
// to the member count. Each request (tuser: operation, tdata: key) goes
// through S_CMP, where every cell compares its entry against the key, then
// S_UPD, where the match bits ripple up the row, a delete shifts each entry
// above the match down one cell, an insert writes the cell at the count, and
// the result is registered; S_UPD waits while the output stage is held. A new
// request is taken in S_IDLE, or in S_UPD while the output stage is free or
// being drained, never in S_CMP. Keys compare on their low KEY_WIDTH bits. An
// absent key inserted into a full set is rejected, status full; no reset sweep.
module set_table_insert_delete_lookup #(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 32,
    localparam int CNT_W    = $clog2(CAPACITY + 1),
    localparam int OUT_W    = ((CNT_W + 5 + 7) / 8) * 8
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              s_tvalid,
    output logic             s_tready,
    input  wire [31:0]       s_tdata,   // key
    input  wire [1:0]        s_tuser,   // cmd
    output logic             m_tvalid,
    input  wire              m_tready,
    output logic [OUT_W-1:0] m_tdata    // hit, status, count_now, empty_flag, full_flag
);
    import stbl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_UPD  = 3'b100
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    cmd_t                 cmd_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 hit_reg;
    status_t              status_reg;
    status_t              status_next;
    logic [CNT_W-1:0]     count_now_reg;
    logic                 empty_reg;
    logic                 full_reg;

    logic                 out_free;
    logic                 upd_go;
    logic                 take;
    logic                 hit;
    logic                 ins_ok;
    logic                 del_ok;
    cell_ctrl_t           ctrl;

    logic [KEY_WIDTH-1:0] entry_w [CAPACITY];
    logic                 seen_w  [CAPACITY+1];

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) || ((state_reg == S_UPD) && out_free);
    assign take     = s_tvalid && s_tready;
    assign upd_go   = (state_reg == S_UPD) && out_free;
    assign hit      = seen_w[CAPACITY];

    assign ctrl.cmp_en = (state_reg == S_CMP);
    assign ctrl.ins_en = upd_go && ins_ok;
    assign ctrl.del_en = upd_go && del_ok;

    assign seen_w[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [KEY_WIDTH-1:0] up_entry;
            if (gi == CAPACITY - 1)
            begin : g_last
                assign up_entry = entry_w[gi];
            end
            else
            begin : g_mid
                assign up_entry = entry_w[gi+1];
            end
            stbl_cell #(
                .INDEX     (gi),
                .KEY_WIDTH (KEY_WIDTH),
                .CNT_W     (CNT_W)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .key       (key_reg),
                .count     (count_reg),
                .entry_in  (up_entry),
                .seen_in   (seen_w[gi]),
                .entry_out (entry_w[gi]),
                .seen_out  (seen_w[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        ins_ok      = 1'b0;
        del_ok      = 1'b0;
        count_next  = count_reg;
        status_next = ST_DONE;
        unique case (cmd_reg)
            CMD_LOOKUP:
            begin
                status_next = hit ? ST_DONE : ST_NOTFOUND;
            end
            CMD_INSERT:
            begin
                if (hit)
                begin
                    status_next = ST_DUP;
                end
                else if (count_reg >= CNT_W'(CAPACITY))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ins_ok     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_DELETE:
            begin
                if (!hit)
                begin
                    status_next = ST_NOTFOUND;
                end
                else
                begin
                    del_ok     = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            CMD_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (take)
                begin
                    state_next = S_CMP;
                end
                else if (upd_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (upd_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (upd_go)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= cmd_t'(s_tuser);
            key_reg <= KEY_WIDTH'(s_tdata);
        end
        if (upd_go)
        begin
            hit_reg       <= hit;
            status_reg    <= status_next;
            count_now_reg <= count_next;
            empty_reg     <= (count_next == '0);
            full_reg      <= (count_next == CNT_W'(CAPACITY));
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({full_reg, empty_reg, count_now_reg, status_reg, hit_reg});

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("member count above capacity");

    a_upd_result: assert property (@(posedge clk) disable iff (!rst_n)
        upd_go |=> m_tvalid)
        else $error("update cycle gave no result");

    a_no_take_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> !s_tready)
        else $error("request taken during compare");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(empty_reg && full_reg))
        else $error("empty and full both set");

    a_cmp_then_upd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |=> (state_reg == S_UPD))
        else $error("compare not followed by update");
`endif

endmodule

`default_nettype wire
